// ===== src/lca_binary_lifting_assert.svh =====
// Assertion macros for the binary-lifting block.
// Each use names a label, an antecedent and a consequent; clk and rst_n
// come from the module that uses the macro.
`ifndef LCA_BINARY_LIFTING_ASSERT_SVH
`define LCA_BINARY_LIFTING_ASSERT_SVH

`ifndef NO_ASSERTIONS
`define LCA_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("lca_binary_lifting: same-cycle check failed");
`define LCA_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("lca_binary_lifting: next-cycle check failed");
`else
`define LCA_ASSERT_IMP(lbl, ante, cons)
`define LCA_ASSERT_NXT(lbl, ante, cons)
`endif

`endif

// ===== src/lca_pkg.sv =====
`timescale 1ns / 1ps

package lca_pkg;

  // Node numbering and table geometry
  localparam int NODE_W      = 10;
  localparam int NODE_COUNT  = 1 << NODE_W;
  localparam int LIFT_LEVELS = 10;
  localparam int LVL_W       = $clog2(LIFT_LEVELS);
  localparam int STEP_W      = 10;
  localparam int DIST_W      = 11;

  // Stream widths
  localparam int IN_DATA_W   = 32;
  localparam int OUT_DATA_W  = 24;
  localparam int USER_W      = 2;

  typedef enum logic [1:0] {
    ACT_INSERT = 2'd0,
    ACT_LCA    = 2'd1,
    ACT_CLIMB  = 2'd2,
    ACT_DIST   = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_MISSING   = 2'd1,
    ST_PAST_ROOT = 2'd2,
    ST_APART     = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_CLR,
    S_IDLE,
    S_CHK,
    S_INS,
    S_CLIMB,
    S_LIFT,
    S_LCA_END,
    S_FIN
  } state_t;

  // One row per node: 2^i-th ancestors, entry 0 is the parent
  typedef logic [LIFT_LEVELS-1:0][NODE_W-1:0] anc_row_t;

  typedef struct packed {
    logic               present;
    logic [NODE_W-1:0]  depth;
    anc_row_t           anc;
  } node_row_t;

endpackage

// ===== src/lca_binary_lifting.sv =====
// Lowest common ancestor by binary lifting over a forest of up to 1023 nodes.
// Each input beat carries an action in in_tuser (insert, common ancestor,
// ancestor at distance, distance) and gives exactly one output beat with a
// status in out_tuser. All node state sits in one row-wide memory (present
// flag, depth and the ten 2^i-th ancestors of a node) with two registered
// read ports and one write port; every step of a climb is one memory read.
// An insert under a parent fills the new row with one read per lift level
// above the parent; a root insert writes its row with no read. Ancestor at
// distance reads one row per set bit of the steps. Common ancestor and
// distance lift the deeper node by one read per set bit of the depth
// difference and, unless one node lies above the other, go on with one pass
// down all lift levels. Failed checks go straight to the result. One item is
// worked on at a time; the next is taken while the previous result waits in
// the output register. After reset a clearing pass marks every node absent,
// during which in_tready stays low.
`timescale 1ns / 1ps

`include "lca_binary_lifting_assert.svh"

module lca_binary_lifting (
  input  logic                               clk,
  input  logic                               rst_n,
  // slave side
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [lca_pkg::IN_DATA_W-1:0]      in_tdata,  // node_a[9:0], node_b[19:10],
                                                        // steps[29:20], zero pad
  input  logic [lca_pkg::USER_W-1:0]         in_tuser,  // action[1:0]
  // master side
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [lca_pkg::OUT_DATA_W-1:0]     out_tdata, // result_node[9:0],
                                                        // result_distance[20:10], zero pad
  output logic [lca_pkg::USER_W-1:0]         out_tuser  // status[1:0]
);

  localparam int NW = lca_pkg::NODE_W;
  localparam int LW = lca_pkg::LVL_W;
  localparam int SW = lca_pkg::STEP_W;
  localparam int DW = lca_pkg::DIST_W;
  localparam int PAD_W = lca_pkg::OUT_DATA_W - DW - NW;

  // Control state
  lca_pkg::state_t    state_r, state_nxt;
  logic [NW-1:0]      clr_cnt_r, clr_cnt_nxt;
  logic               out_valid_r, out_valid_nxt;

  // Working registers
  lca_pkg::action_t   act_r, act_nxt;
  logic [NW-1:0]      a_r, a_nxt;
  logic [NW-1:0]      b_r, b_nxt;
  logic [NW-1:0]      u_r, u_nxt;
  logic [NW-1:0]      v_r, v_nxt;
  logic [SW-1:0]      k_r, k_nxt;
  logic [NW-1:0]      dcur_r, dcur_nxt;
  logic [DW-1:0]      sum_r, sum_nxt;
  logic [NW-1:0]      dep_r, dep_nxt;
  logic [LW-1:0]      lvl_r, lvl_nxt;
  lca_pkg::anc_row_t  rowbuf_r, rowbuf_nxt;
  logic [NW-1:0]      res_node_r, res_node_nxt;
  logic [DW-1:0]      res_dist_r, res_dist_nxt;
  lca_pkg::status_t   res_stat_r, res_stat_nxt;
  logic [NW-1:0]      out_node_r, out_node_nxt;
  logic [DW-1:0]      out_dist_r, out_dist_nxt;
  lca_pkg::status_t   out_stat_r, out_stat_nxt;

  // Node memory ports
  lca_pkg::node_row_t mem [lca_pkg::NODE_COUNT];
  lca_pkg::node_row_t rd_a_r, rd_b_r;
  logic               rd_a_en, rd_b_en;
  logic [NW-1:0]      rd_a_addr, rd_b_addr;
  logic               wr_en;
  logic [NW-1:0]      wr_addr;
  lca_pkg::node_row_t wr_row;

  // Decode helpers
  logic               accept;
  logic               out_free;
  logic               a_ok, b_ok, ins_bad;
  lca_pkg::status_t   chk_stat;
  logic               a_deeper;
  logic [LW-1:0]      low_idx;
  logic [LW-1:0]      lvl_m1;
  logic [NW-1:0]      half;
  logic [NW-1:0]      ins_ent;
  logic               lift_diff;
  logic               ins_last;
  logic [NW-1:0]      fin_w;
  logic [NW-1:0]      fin_dw;

  assign accept     = in_tvalid && in_tready;
  assign in_tready  = (state_r == lca_pkg::S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{PAD_W{1'b0}}, out_dist_r, out_node_r};
  assign out_tuser  = out_stat_r;
  assign out_free   = !out_valid_r || out_tready;

  // Row memory: one write port, two registered read ports
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_row;
    end
    if (rd_a_en) begin
      rd_a_r <= mem[rd_a_addr];
    end
    if (rd_b_en) begin
      rd_b_r <= mem[rd_b_addr];
    end
  end

  // Presence and range checks on the rows read at accept
  always_comb begin
    a_ok     = (a_r != '0) && rd_a_r.present;
    b_ok     = (b_r != '0) && rd_b_r.present;
    ins_bad  = (a_r == '0) || rd_a_r.present || ((b_r != '0) && !rd_b_r.present);
    a_deeper = !(rd_a_r.depth < rd_b_r.depth);
    chk_stat = lca_pkg::ST_OK;
    unique case (act_r)
      lca_pkg::ACT_INSERT: begin
        if (ins_bad) chk_stat = lca_pkg::ST_MISSING;
      end
      lca_pkg::ACT_CLIMB: begin
        if (!a_ok) chk_stat = lca_pkg::ST_MISSING;
        else if (k_r > rd_a_r.depth) chk_stat = lca_pkg::ST_PAST_ROOT;
      end
      default: begin
        if (!(a_ok && b_ok)) chk_stat = lca_pkg::ST_MISSING;
      end
    endcase
  end

  // Lowest set bit of the remaining climb
  always_comb begin
    low_idx = '0;
    for (int i = lca_pkg::LIFT_LEVELS - 1; i >= 0; i--) begin
      if (k_r[i]) low_idx = LW'(i);
    end
  end

  // Row fill and lift helpers
  assign lvl_m1    = LW'(lvl_r - 1'b1);
  assign half      = rowbuf_r[lvl_m1];
  assign ins_ent   = (half != '0) ? rd_a_r.anc[lvl_m1] : '0;
  assign ins_last  = (lvl_r == LW'(lca_pkg::LIFT_LEVELS - 1));
  assign lift_diff = (rd_a_r.anc[lvl_r] != rd_b_r.anc[lvl_r]);

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      lca_pkg::S_CLR: begin
        if (clr_cnt_r == '1) state_nxt = lca_pkg::S_IDLE;
      end
      lca_pkg::S_IDLE: begin
        if (accept) state_nxt = lca_pkg::S_CHK;
      end
      lca_pkg::S_CHK: begin
        if (chk_stat != lca_pkg::ST_OK) state_nxt = lca_pkg::S_FIN;
        else if (act_r == lca_pkg::ACT_INSERT) begin
          state_nxt = (b_r == '0) ? lca_pkg::S_FIN : lca_pkg::S_INS;
        end else state_nxt = lca_pkg::S_CLIMB;
      end
      lca_pkg::S_INS: begin
        if (ins_last) state_nxt = lca_pkg::S_FIN;
      end
      lca_pkg::S_CLIMB: begin
        if (k_r == '0) begin
          if (act_r == lca_pkg::ACT_CLIMB || u_r == v_r) state_nxt = lca_pkg::S_FIN;
          else state_nxt = lca_pkg::S_LIFT;
        end
      end
      lca_pkg::S_LIFT: begin
        if (lvl_r == '0) state_nxt = lca_pkg::S_LCA_END;
      end
      lca_pkg::S_LCA_END: state_nxt = lca_pkg::S_FIN;
      lca_pkg::S_FIN: begin
        if (out_free) state_nxt = lca_pkg::S_IDLE;
      end
      default: state_nxt = lca_pkg::S_IDLE;
    endcase
  end

  // Common ancestor and its depth at the end of a query
  always_comb begin
    if (state_r == lca_pkg::S_LCA_END) begin
      fin_w  = rd_a_r.anc[0];
      fin_dw = NW'(dcur_r - 1'b1);
    end else begin
      fin_w  = u_r;
      fin_dw = dcur_r;
    end
  end

  // Datapath, memory control and result registers
  always_comb begin
    clr_cnt_nxt   = clr_cnt_r;
    out_valid_nxt = out_valid_r && !out_tready;
    act_nxt       = act_r;
    a_nxt         = a_r;
    b_nxt         = b_r;
    u_nxt         = u_r;
    v_nxt         = v_r;
    k_nxt         = k_r;
    dcur_nxt      = dcur_r;
    sum_nxt       = sum_r;
    dep_nxt       = dep_r;
    lvl_nxt       = lvl_r;
    rowbuf_nxt    = rowbuf_r;
    res_node_nxt  = res_node_r;
    res_dist_nxt  = res_dist_r;
    res_stat_nxt  = res_stat_r;
    out_node_nxt  = out_node_r;
    out_dist_nxt  = out_dist_r;
    out_stat_nxt  = out_stat_r;
    rd_a_en       = 1'b0;
    rd_b_en       = 1'b0;
    rd_a_addr     = a_r;
    rd_b_addr     = b_r;
    wr_en         = 1'b0;
    wr_addr       = a_r;
    wr_row        = '0;

    unique case (state_r)
      // Mark every node absent after reset
      lca_pkg::S_CLR: begin
        wr_en       = 1'b1;
        wr_addr     = clr_cnt_r;
        clr_cnt_nxt = NW'(clr_cnt_r + 1'b1);
      end

      // Take a beat and fetch both node rows
      lca_pkg::S_IDLE: begin
        if (accept) begin
          act_nxt   = lca_pkg::action_t'(in_tuser);
          a_nxt     = in_tdata[NW-1:0];
          b_nxt     = in_tdata[2*NW-1:NW];
          k_nxt     = in_tdata[2*NW+SW-1:2*NW];
          rd_a_en   = 1'b1;
          rd_b_en   = 1'b1;
          rd_a_addr = in_tdata[NW-1:0];
          rd_b_addr = in_tdata[2*NW-1:NW];
        end
      end

      // Validate and set up the walk
      lca_pkg::S_CHK: begin
        res_node_nxt = '0;
        res_dist_nxt = '0;
        res_stat_nxt = chk_stat;
        if (chk_stat == lca_pkg::ST_OK) begin
          unique case (act_r)
            lca_pkg::ACT_INSERT: begin
              dep_nxt       = (b_r != '0) ? NW'(rd_b_r.depth + 1'b1) : '0;
              rowbuf_nxt    = '0;
              rowbuf_nxt[0] = b_r;
              lvl_nxt       = LW'(1);
              if (b_r == '0) begin
                wr_en          = 1'b1;
                wr_row.present = 1'b1;
              end else begin
                rd_a_en   = 1'b1;
                rd_a_addr = b_r;
              end
            end
            lca_pkg::ACT_CLIMB: begin
              u_nxt     = a_r;
              v_nxt     = '0;
              rd_a_en   = 1'b1;
              rd_a_addr = a_r;
            end
            default: begin
              sum_nxt = DW'(rd_a_r.depth) + DW'(rd_b_r.depth);
              if (a_deeper) begin
                u_nxt    = a_r;
                v_nxt    = b_r;
                k_nxt    = SW'(rd_a_r.depth - rd_b_r.depth);
                dcur_nxt = rd_b_r.depth;
              end else begin
                u_nxt    = b_r;
                v_nxt    = a_r;
                k_nxt    = SW'(rd_b_r.depth - rd_a_r.depth);
                dcur_nxt = rd_a_r.depth;
              end
              rd_a_en   = 1'b1;
              rd_b_en   = 1'b1;
              rd_a_addr = u_nxt;
              rd_b_addr = v_nxt;
            end
          endcase
        end
      end

      // Fill the new node's row one level per read
      lca_pkg::S_INS: begin
        rowbuf_nxt[lvl_r] = ins_ent;
        if (ins_last) begin
          wr_en          = 1'b1;
          wr_row.present = 1'b1;
          wr_row.depth   = dep_r;
          wr_row.anc     = rowbuf_nxt;
        end else begin
          rd_a_en   = 1'b1;
          rd_a_addr = ins_ent;
          lvl_nxt   = LW'(lvl_r + 1'b1);
        end
      end

      // Climb one set bit of the remaining distance per read
      lca_pkg::S_CLIMB: begin
        if (k_r != '0) begin
          u_nxt     = rd_a_r.anc[low_idx];
          k_nxt     = k_r & SW'(k_r - 1'b1);
          rd_a_en   = 1'b1;
          rd_a_addr = u_nxt;
        end else if (act_r == lca_pkg::ACT_CLIMB) begin
          res_node_nxt = u_r;
        end else if (u_r == v_r) begin
          res_node_nxt = (act_r == lca_pkg::ACT_LCA) ? fin_w : '0;
          res_dist_nxt = (act_r == lca_pkg::ACT_DIST) ? DW'(sum_r - {fin_dw, 1'b0}) : '0;
        end else begin
          lvl_nxt = LW'(lca_pkg::LIFT_LEVELS - 1);
        end
      end

      // Lift both nodes while their ancestors differ
      lca_pkg::S_LIFT: begin
        if (lift_diff) begin
          u_nxt     = rd_a_r.anc[lvl_r];
          v_nxt     = rd_b_r.anc[lvl_r];
          dcur_nxt  = NW'(dcur_r - (NW'(1) << lvl_r));
          rd_a_en   = 1'b1;
          rd_b_en   = 1'b1;
          rd_a_addr = u_nxt;
          rd_b_addr = v_nxt;
        end
        lvl_nxt = LW'(lvl_r - 1'b1);
      end

      // Parent of the lifted node is the common ancestor
      lca_pkg::S_LCA_END: begin
        if (fin_w == '0) begin
          res_stat_nxt = lca_pkg::ST_APART;
          res_node_nxt = '0;
          res_dist_nxt = '0;
        end else begin
          res_node_nxt = (act_r == lca_pkg::ACT_LCA) ? fin_w : '0;
          res_dist_nxt = (act_r == lca_pkg::ACT_DIST) ? DW'(sum_r - {fin_dw, 1'b0}) : '0;
        end
      end

      // Hand the result to the output register
      lca_pkg::S_FIN: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_node_nxt  = res_node_r;
          out_dist_nxt  = res_dist_r;
          out_stat_nxt  = res_stat_r;
        end
      end

      default: ;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= lca_pkg::S_CLR;
      clr_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    act_r      <= act_nxt;
    a_r        <= a_nxt;
    b_r        <= b_nxt;
    u_r        <= u_nxt;
    v_r        <= v_nxt;
    k_r        <= k_nxt;
    dcur_r     <= dcur_nxt;
    sum_r      <= sum_nxt;
    dep_r      <= dep_nxt;
    lvl_r      <= lvl_nxt;
    rowbuf_r   <= rowbuf_nxt;
    res_node_r <= res_node_nxt;
    res_dist_r <= res_dist_nxt;
    res_stat_r <= res_stat_nxt;
    out_node_r <= out_node_nxt;
    out_dist_r <= out_dist_nxt;
    out_stat_r <= out_stat_nxt;
  end

  // Checks
  `LCA_ASSERT_IMP(a_wr_only_clear_or_insert, wr_en, (state_r == lca_pkg::S_CLR) || (act_r == lca_pkg::ACT_INSERT))
  `LCA_ASSERT_NXT(a_climb_shrinks, (state_r == lca_pkg::S_CLIMB) && (k_r != '0), k_r < $past(k_r))
  `LCA_ASSERT_NXT(a_accept_to_check, accept, state_r == lca_pkg::S_CHK)

endmodule
